/* src/tfet_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfet_pkg
// Shared types, constants and functions for the TCP flow event tracker.
// ----------------------------------------------------------------------------
package tfet_pkg;

  localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
  localparam logic [31:0] LFSR_TAPS = 32'h80200003;
  localparam int unsigned MAX_BUCKET = 24;
  localparam logic [63:0] NS_PER_US = 64'd1000;

  localparam logic [2:0] EV_SYN         = 3'd0;
  localparam logic [2:0] EV_ESTABLISHED = 3'd1;
  localparam logic [2:0] EV_RETRANSMIT  = 3'd2;
  localparam logic [2:0] EV_RTT         = 3'd3;
  localparam logic [2:0] EV_RST         = 3'd4;
  localparam logic [2:0] EV_FIN         = 3'd5;

  localparam logic [1:0] SIDE_NONE   = 2'd0;
  localparam logic [1:0] SIDE_GUEST  = 2'd1;
  localparam logic [1:0] SIDE_REMOTE = 2'd2;

  localparam logic CFG_VM_KEY    = 1'b0;
  localparam logic CFG_THIN_RATE = 1'b1;

  typedef struct packed {
    logic [63:0] syn_time;
    logic        is_established;
    logic [1:0]  syn_side;
    logic [31:0] out_span_start;
    logic [31:0] out_span_end;
    logic [63:0] out_data_time;
    logic [31:0] in_span_start;
    logic [31:0] in_span_end;
    logic [63:0] in_data_time;
    logic [31:0] guest_ack_seen;
    logic [31:0] remote_ack_seen;
  } flow_entry_t;

  // log2 bucket of ceil(ns/1000): ceil(ns/1000) >= 2^k exactly when ns > 1000*(2^k-1)
  function automatic logic [4:0] latency_bucket(input logic [63:0] ns);
    logic [4:0] b;
    b = 5'd0;
    for (int k = 1; k <= MAX_BUCKET; k++) begin
      if (ns > NS_PER_US * ((64'd1 << k) - 64'd1)) begin
        b = 5'(k);
      end
    end
    return b;
  endfunction

  function automatic logic [31:0] lfsr_next(input logic [31:0] s);
    return s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
  endfunction

endpackage
`default_nettype wire

/* src/tcp_flow_event_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_flow_event_tracker
// Per-flow TCP handshake, retransmit, RTT, RST and FIN event generator.
// ----------------------------------------------------------------------------
// Sequencing: a request's flow entry is registered on accept and written back
//   in ST_CALC; results follow one per cycle while out_ready is high.
// Ordering: requests are taken only once all results of the last one are out; for
//   an RTT sample with thin_rate != 0 a bit-serial lfsr % thin_rate runs first.
// Reset: clears control state and loads the LFSR seed; flow memory content is
//   undefined until a slot is written with new_flow.
module tcp_flow_event_tracker #(
  parameter int FLOW_ENTRIES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_direction,
  input  wire logic [9:0]  in_flow_index,
  input  wire logic        in_new_flow,
  input  wire logic        in_syn_flag,
  input  wire logic        in_ack_flag,
  input  wire logic        in_rst_flag,
  input  wire logic        in_fin_flag,
  input  wire logic [31:0] in_seq_number,
  input  wire logic [31:0] in_ack_number,
  input  wire logic [15:0] in_payload_length,
  input  wire logic [63:0] in_arrival_ns,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_kind,
  output logic             out_event_direction,
  output logic [31:0]      out_event_seq,
  output logic [31:0]      out_event_ack,
  output logic [63:0]      out_elapsed_ns,
  output logic [4:0]       out_latency_bucket,
  output logic [63:0]      out_event_time,
  output logic             out_last_event
);
  import tfet_pkg::*;

  localparam int AW = $clog2(FLOW_ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  // pending event bits, lowest goes out first
  localparam int B_SYN  = 0;
  localparam int B_SRTX = 1;
  localparam int B_EST  = 2;
  localparam int B_DRTX = 3;
  localparam int B_RTT  = 4;
  localparam int B_RST  = 5;
  localparam int B_FIN  = 6;

  flow_entry_t flow_mem [FLOW_ENTRIES];

  logic [1:0]  state_r;
  logic [63:0] vm_key_r;
  logic [31:0] thin_rate_r;
  logic [31:0] lfsr_r;

  logic        dir_r, new_r, syn_r, ackf_r, rstf_r, finf_r;
  logic [31:0] seq_r, ack_r;
  logic [15:0] len_r;
  logic [63:0] now_r;
  logic [AW-1:0] idx_r;
  flow_entry_t rd_r;

  logic [6:0]  mask_r;
  logic [63:0] est_dur_r, rtt_dur_r;
  logic [31:0] div_rem_r, div_dvd_r;
  logic [4:0]  div_cnt_r;

  logic          accept;
  logic [AW+9:0] idx_ext;
  assign accept   = in_valid & in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign idx_ext  = {{AW{1'b0}}, in_flow_index};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_key_r    <= '0;
      thin_rate_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VM_KEY:    vm_key_r <= cfg_wdata;
        CFG_THIN_RATE: thin_rate_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // request capture and flow memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      dir_r  <= in_direction;
      new_r  <= in_new_flow;
      syn_r  <= in_syn_flag;
      ackf_r <= in_ack_flag;
      rstf_r <= in_rst_flag;
      finf_r <= in_fin_flag;
      seq_r  <= in_seq_number;
      ack_r  <= in_ack_number;
      len_r  <= in_payload_length;
      now_r  <= in_arrival_ns;
      idx_r  <= idx_ext[AW-1:0];
      rd_r   <= flow_mem[idx_ext[AW-1:0]];
    end
  end

  // flow update
  flow_entry_t e, e_nxt;
  logic [1:0]  side, other;
  logic [31:0] end_seq, own_ss, own_se, peer_end, ack_seen;
  logic [63:0] peer_time;
  logic        syn_pend, rtt_hit;
  logic [6:0]  mask_nxt;

  always_comb begin
    e        = new_r ? '0 : rd_r;
    e_nxt    = e;
    side     = dir_r ? SIDE_REMOTE : SIDE_GUEST;
    other    = dir_r ? SIDE_GUEST : SIDE_REMOTE;
    end_seq  = seq_r + 32'(len_r);
    mask_nxt = '0;
    own_ss    = dir_r ? e.in_span_start : e.out_span_start;
    own_se    = dir_r ? e.in_span_end : e.out_span_end;
    peer_end  = dir_r ? e.out_span_end : e.in_span_end;
    peer_time = dir_r ? e.out_data_time : e.in_data_time;
    ack_seen  = dir_r ? e.remote_ack_seen : e.guest_ack_seen;
    syn_pend  = (e.syn_time != 64'd0) & ~e.is_established;

    // handshake
    if (syn_r & ~ackf_r) begin
      if (syn_pend & (e.syn_side == side)) begin
        mask_nxt[B_SRTX] = 1'b1;
      end else if ((e.syn_time == 64'd0) | e.is_established) begin
        e_nxt.syn_time       = now_r;
        e_nxt.syn_side       = side;
        e_nxt.is_established = 1'b0;
        mask_nxt[B_SYN]      = 1'b1;
      end
    end else if (syn_r & ackf_r & (e.syn_side == other) & syn_pend) begin
      e_nxt.is_established = 1'b1;
      mask_nxt[B_EST]      = 1'b1;
    end

    // data span
    if (len_r != 16'd0) begin
      if ((own_ss == seq_r) & (own_se == end_seq)) begin
        mask_nxt[B_DRTX] = 1'b1;
      end
      if (dir_r) begin
        e_nxt.in_span_start = seq_r;
        e_nxt.in_span_end   = end_seq;
        e_nxt.in_data_time  = now_r;
      end else begin
        e_nxt.out_span_start = seq_r;
        e_nxt.out_span_end   = end_seq;
        e_nxt.out_data_time  = now_r;
      end
    end

    // rtt sample
    rtt_hit = ackf_r & (peer_time != 64'd0) & (peer_end != 32'd0) &
              (ack_r >= peer_end) & (ack_r != ack_seen);
    if (rtt_hit) begin
      if (dir_r) begin
        e_nxt.remote_ack_seen = ack_r;
      end else begin
        e_nxt.guest_ack_seen = ack_r;
      end
    end

    mask_nxt[B_RST] = rstf_r;
    mask_nxt[B_FIN] = finf_r;
  end

  // memory write back
  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      flow_mem[idx_r] <= e_nxt;
    end
  end

  // bit-serial remainder step
  logic [32:0] div_try;
  assign div_try = {div_rem_r, div_dvd_r[31]} - {1'b0, thin_rate_r};

  // event selection
  logic [2:0]  sel;
  logic [6:0]  mask_clr;
  logic [2:0]  sel_type;
  logic [63:0] sel_dur;
  logic        out_free;
  logic        emit_go;

  always_comb begin
    sel = 3'd0;
    for (int i = 6; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = 3'(i);
      end
    end
    mask_clr      = mask_r;
    mask_clr[sel] = 1'b0;
    case (sel)
      3'(B_SYN):  sel_type = EV_SYN;
      3'(B_SRTX): sel_type = EV_RETRANSMIT;
      3'(B_EST):  sel_type = EV_ESTABLISHED;
      3'(B_DRTX): sel_type = EV_RETRANSMIT;
      3'(B_RTT):  sel_type = EV_RTT;
      3'(B_RST):  sel_type = EV_RST;
      default:    sel_type = EV_FIN;
    endcase
    case (sel)
      3'(B_EST): sel_dur = est_dur_r;
      3'(B_RTT): sel_dur = rtt_dur_r;
      default:   sel_dur = 64'd0;
    endcase
  end

  assign out_free = ~out_valid | out_ready;
  assign emit_go  = (state_r == ST_EMIT) & (mask_r != 7'd0) & out_free;

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      lfsr_r    <= LFSR_SEED;
      out_valid <= 1'b0;
      mask_r    <= '0;
    end else begin
      out_valid <= emit_go | (out_valid & ~out_ready);
      case (state_r)
        ST_IDLE: begin
          if (accept & (vm_key_r != 64'd0)) begin
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          mask_r    <= mask_nxt;
          est_dur_r <= now_r - e.syn_time;
          rtt_dur_r <= now_r - peer_time;
          if (rtt_hit & (thin_rate_r != 32'd0)) begin
            lfsr_r    <= lfsr_next(lfsr_r);
            div_dvd_r <= lfsr_next(lfsr_r);
            div_rem_r <= '0;
            div_cnt_r <= '1;
            state_r   <= ST_MOD;
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_MOD: begin
          div_dvd_r <= div_dvd_r << 1;
          div_rem_r <= div_try[32] ? {div_rem_r[30:0], div_dvd_r[31]} : div_try[31:0];
          div_cnt_r <= div_cnt_r - 5'd1;
          if (div_cnt_r == 5'd0) begin
            mask_r[B_RTT] <= div_try[32] ? ({div_rem_r[30:0], div_dvd_r[31]} == 32'd0)
                                         : (div_try[31:0] == 32'd0);
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (mask_r == 7'd0) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            mask_r <= mask_clr;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_event_kind      <= sel_type;
      out_event_direction <= dir_r;
      out_event_seq       <= seq_r;
      out_event_ack       <= ack_r;
      out_elapsed_ns      <= sel_dur;
      out_latency_bucket  <= latency_bucket(sel_dur);
      out_event_time      <= now_r;
      out_last_event      <= (mask_clr == 7'd0);
    end
  end

endmodule
`default_nettype wire
